// ===== rtl/ttpm_pkg.sv =====
// Shared types, constants and constant tables of the tile-turn pixel mapper.
// Used by ttpm_recip_div and tile_turn_pixel_mapper_core; depends on nothing.
package ttpm_pkg;

	localparam int TILE_BITS  = 6;                    // 64 x 64 pixel tiles
	localparam int COORD_W    = 12;                   // sample coordinate width
	localparam int PIXEL_W    = 13;                   // signed destination coordinate
	localparam int PHASE_CFG_W = 9;                   // signed frame phase register
	localparam int FIX_BITS   = 16;                   // 16.16 fixed point steps
	localparam int DEN_W      = 6;                    // divisors are 0..63
	localparam int SPAN_NUM_W = 12;                   // span and edge numerators
	localparam int STEP_NUM_W = FIX_BITS + TILE_BITS; // step numerators
	localparam int GLOSS_W    = 8;

	typedef logic [TILE_BITS-1:0] tcoord_t;

	localparam tcoord_t EDGE       = '1;              // last pixel inside a tile
	localparam tcoord_t LAST_PHASE = '1;              // fully turned tile
	localparam tcoord_t FIRST_PHASE = '0;             // untouched tile

	// Fold corners of the turning tile for one phase.
	typedef struct packed {
		tcoord_t ax;
		tcoord_t ay;
	} corner_t;

	// Corner positions per phase. Phases that are not listed (the two pass-through
	// phases, 1..5 where the fold has not moved yet, and 58..62) sit at the tile edge.
	function automatic corner_t ttpm_corner(input tcoord_t ph);
		corner_t c;
		case (ph) inside
			6'd6, 6'd7:   c = '{ax: 6'd1,  ay: 6'd62};
			6'd8, 6'd9:   c = '{ax: 6'd2,  ay: 6'd61};
			6'd10, 6'd11: c = '{ax: 6'd3,  ay: 6'd60};
			6'd12:        c = '{ax: 6'd4,  ay: 6'd59};
			6'd13:        c = '{ax: 6'd5,  ay: 6'd58};
			6'd14:        c = '{ax: 6'd5,  ay: 6'd56};
			6'd15:        c = '{ax: 6'd6,  ay: 6'd55};
			6'd16:        c = '{ax: 6'd7,  ay: 6'd54};
			6'd17:        c = '{ax: 6'd8,  ay: 6'd53};
			6'd18:        c = '{ax: 6'd9,  ay: 6'd52};
			6'd19:        c = '{ax: 6'd9,  ay: 6'd50};
			6'd20:        c = '{ax: 6'd10, ay: 6'd49};
			6'd21:        c = '{ax: 6'd12, ay: 6'd47};
			6'd22:        c = '{ax: 6'd13, ay: 6'd46};
			6'd23:        c = '{ax: 6'd15, ay: 6'd44};
			6'd24:        c = '{ax: 6'd15, ay: 6'd42};
			6'd25:        c = '{ax: 6'd17, ay: 6'd40};
			6'd26:        c = '{ax: 6'd18, ay: 6'd39};
			6'd27:        c = '{ax: 6'd20, ay: 6'd37};
			6'd28:        c = '{ax: 6'd22, ay: 6'd35};
			6'd29:        c = '{ax: 6'd24, ay: 6'd33};
			6'd30:        c = '{ax: 6'd26, ay: 6'd31};
			6'd31:        c = '{ax: 6'd28, ay: 6'd29};
			6'd32:        c = '{ax: 6'd34, ay: 6'd35};
			6'd33:        c = '{ax: 6'd32, ay: 6'd37};
			6'd34:        c = '{ax: 6'd30, ay: 6'd39};
			6'd35:        c = '{ax: 6'd28, ay: 6'd41};
			6'd36:        c = '{ax: 6'd26, ay: 6'd43};
			6'd37:        c = '{ax: 6'd24, ay: 6'd45};
			6'd38:        c = '{ax: 6'd23, ay: 6'd46};
			6'd39:        c = '{ax: 6'd21, ay: 6'd48};
			6'd40:        c = '{ax: 6'd19, ay: 6'd48};
			6'd41:        c = '{ax: 6'd17, ay: 6'd50};
			6'd42:        c = '{ax: 6'd16, ay: 6'd51};
			6'd43:        c = '{ax: 6'd14, ay: 6'd53};
			6'd44:        c = '{ax: 6'd13, ay: 6'd54};
			6'd45:        c = '{ax: 6'd11, ay: 6'd54};
			6'd46:        c = '{ax: 6'd10, ay: 6'd55};
			6'd47:        c = '{ax: 6'd9,  ay: 6'd56};
			6'd48:        c = '{ax: 6'd8,  ay: 6'd57};
			6'd49:        c = '{ax: 6'd7,  ay: 6'd58};
			6'd50:        c = '{ax: 6'd5,  ay: 6'd58};
			6'd51:        c = '{ax: 6'd4,  ay: 6'd59};
			6'd52, 6'd53: c = '{ax: 6'd3,  ay: 6'd60};
			6'd54, 6'd55: c = '{ax: 6'd2,  ay: 6'd61};
			6'd56, 6'd57: c = '{ax: 6'd1,  ay: 6'd62};
			default:      c = '{ax: 6'd0,  ay: 6'd63};
		endcase
		return c;
	endfunction

	// White gloss level out of 256, only lit around the start of the turn.
	function automatic logic [GLOSS_W-1:0] ttpm_gloss(input tcoord_t ph);
		logic [GLOSS_W-1:0] g;
		case (ph) inside
			6'd4, 6'd12: g = 8'd16;
			6'd5, 6'd11: g = 8'd48;
			6'd6, 6'd10: g = 8'd80;
			6'd7, 6'd9:  g = 8'd128;
			6'd8:        g = 8'd192;
			default:     g = 8'd0;
		endcase
		return g;
	endfunction

endpackage

// ===== rtl/ttpm_recip_div.sv =====
// Registered unsigned divider by a 6-bit divisor: reciprocal table and one multiply.
// Depends on ttpm_pkg for the divisor width.
module ttpm_recip_div #(
	parameter int NUM_W = 12    // 1..24; exact floor for every numerator of this width
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [NUM_W-1:0]            num,
	input  logic [ttpm_pkg::DEN_W-1:0]  den,
	output logic [NUM_W-1:0]            quo
);
	import ttpm_pkg::*;

	// With a shift of NUM_W + DEN_W the rounded-up reciprocal gives the exact floor.
	localparam int SHIFT   = NUM_W + DEN_W;
	localparam int RECIP_W = SHIFT + 1;
	localparam int DEPTH   = 1 << DEN_W;

	logic [RECIP_W-1:0]       recip_tab [DEPTH];
	logic [RECIP_W-1:0]       recip;
	logic [NUM_W+RECIP_W-1:0] prod;
	logic [NUM_W-1:0]         quo_q;

	// A zero divisor yields a zero quotient, which the datapath relies on.
	assign recip_tab[0] = '0;
	for (genvar Den = 1; Den < DEPTH; Den++) begin : g_recip
		localparam longint RV = ((longint'(1) << SHIFT) + Den - 1) / Den;
		assign recip_tab[Den] = RECIP_W'(RV);
	end

	assign recip = recip_tab[den];
	assign prod  = {{RECIP_W{1'b0}}, num} * {{NUM_W{1'b0}}, recip};

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= NUM_W'(prod >> SHIFT);
		end
	end

	assign quo = quo_q;

endmodule

// ===== rtl/tile_turn_pixel_mapper_core.sv =====
// Tile-turn pixel mapper: maps each destination pixel to its sample position.
// Depends on ttpm_pkg and instantiates ttpm_recip_div.
//
// Channel  | Direction | Handshake                   | Payload
// ---------+-----------+-----------------------------+----------------------------------------
// config   | in        | global_phase_we             | global_phase
// pixel    | in        | in_valid / in_stall         | pixel_x, pixel_y
// result   | out       | out_valid / out_stall       | blank, second_image, source_x,
//          |           |                             | source_y, gloss_level
//
// One transaction per clock is accepted while the result is not stalled, and one result per
// transaction is produced through seven register stages, of which S3 and S5 hold the dividers.
// Reset (arst_n low) empties the pipeline and sets the global phase to zero.
// A stalled result freezes the whole pipeline in place, so in_stall is out_valid and
// out_stall; bubbles are carried along as invalid stages and nothing is dropped.
//
// Stage plan:
//   S1  split coordinates into tile and offset, compute and clamp the tile phase.
//   S2  look up the fold corners and form numerators and divisors of the span edges.
//   S3  divide (reciprocal multiply) for span left/right and the source edge points.
//   S4  assemble span, edge points and the step numerators; test the pixel against the span.
//   S5  divide the source delta by the span length minus one for the 16.16 steps.
//   S6  multiply each signed step by the advance along the span.
//   S7  add the tile base and start point, select the result: this is the output register.
module tile_turn_pixel_mapper_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    global_phase_we,
	input  logic signed [ttpm_pkg::PHASE_CFG_W-1:0] global_phase,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [ttpm_pkg::PIXEL_W-1:0]     pixel_x,
	input  logic signed [ttpm_pkg::PIXEL_W-1:0]     pixel_y,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic                                    blank,
	output logic                                    second_image,
	output logic [ttpm_pkg::COORD_W-1:0]            source_x,
	output logic [ttpm_pkg::COORD_W-1:0]            source_y,
	output logic [ttpm_pkg::GLOSS_W-1:0]            gloss_level
);
	import ttpm_pkg::*;

	// Per-pixel facts that ride along the pipeline next to the arithmetic.
	typedef struct packed {
		logic                neg;     // negative coordinate: nothing to show
		logic                pass;    // tile at rest: sample the pixel itself
		logic                second;  // sample the second image
		logic [GLOSS_W-1:0]  gloss;
		tcoord_t             tx;
		tcoord_t             ty;
		tcoord_t             wx;
		tcoord_t             wy;
	} side_t;

	localparam int PHASE_RAW_W = PHASE_CFG_W + 2;
	localparam int PROD_W      = STEP_NUM_W + 1 + TILE_BITS + 1;

	// The pipeline moves as one unless a finished result is waiting.
	logic pipe_en;
	assign pipe_en  = !(out_valid && out_stall);
	assign in_stall = !pipe_en;

	// Configuration register.
	logic signed [PHASE_CFG_W-1:0] gphase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gphase_q <= '0;
		end else if (global_phase_we) begin
			gphase_q <= global_phase;
		end
	end

	// Valid bits of the stages.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// ---------------------------------------------------------------- S1
	// The tile phase runs two steps behind per tile to the right and two steps ahead
	// per tile downward, and is clamped to the phase range.
	logic                          neg_in;
	tcoord_t                       tx_in, ty_in, wx_in, wy_in, ph_in;
	logic signed [PHASE_RAW_W-1:0] ph_raw;

	assign neg_in = pixel_x[PIXEL_W-1] | pixel_y[PIXEL_W-1];
	assign tx_in  = pixel_x[COORD_W-1:TILE_BITS];
	assign ty_in  = pixel_y[COORD_W-1:TILE_BITS];
	assign wx_in  = pixel_x[TILE_BITS-1:0];
	assign wy_in  = pixel_y[TILE_BITS-1:0];

	always_comb begin
		ph_raw = PHASE_RAW_W'(gphase_q)
		       - PHASE_RAW_W'(signed'({1'b0, tx_in, 1'b0}))
		       + PHASE_RAW_W'(signed'({1'b0, ty_in, 1'b0}));
		if (ph_raw < 0) begin
			ph_in = FIRST_PHASE;
		end else if (ph_raw > PHASE_RAW_W'(signed'({1'b0, LAST_PHASE}))) begin
			ph_in = LAST_PHASE;
		end else begin
			ph_in = ph_raw[TILE_BITS-1:0];
		end
	end

	logic    neg_s1;
	tcoord_t tx_s1, ty_s1, wx_s1, wy_s1, ph_s1;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			neg_s1 <= neg_in;
			tx_s1  <= tx_in;
			ty_s1  <= ty_in;
			wx_s1  <= wx_in;
			wy_s1  <= wy_in;
			ph_s1  <= ph_in;
		end
	end

	// ---------------------------------------------------------------- S2
	// The turned tile is a quadrilateral whose left side runs through corner A
	// and whose right side runs through corner B, the point mirrored about the
	// tile center. Each edge on a row is a base plus a quotient.
	function automatic logic [SPAN_NUM_W-1:0] mul6(input tcoord_t a, input tcoord_t b);
		return SPAN_NUM_W'({6'b0, a} * {6'b0, b});
	endfunction

	corner_t                 cn;
	tcoord_t                 bx, by;
	logic                    a_le, b_le;
	side_t                   side_in2;
	logic [SPAN_NUM_W-1:0]   ln, rn, sn, en_num;
	tcoord_t                 ld, rd, sd, ed, lb, rb;

	assign cn   = ttpm_corner(ph_s1);
	assign bx   = EDGE - cn.ax;
	assign by   = EDGE - cn.ay;
	assign a_le = wy_s1 <= cn.ay;
	assign b_le = wy_s1 <= by;

	always_comb begin
		side_in2.neg    = neg_s1;
		side_in2.pass   = (ph_s1 == FIRST_PHASE) || (ph_s1 == LAST_PHASE);
		side_in2.second = ph_s1[TILE_BITS-1];
		side_in2.gloss  = ttpm_gloss(ph_s1);
		side_in2.tx     = tx_s1;
		side_in2.ty     = ty_s1;
		side_in2.wx     = wx_s1;
		side_in2.wy     = wy_s1;

		// Left edge of the span.
		if (a_le) begin
			lb = '0;
			ln = mul6(cn.ax, wy_s1);
			ld = cn.ay;
		end else if (cn.ay == EDGE) begin
			lb = EDGE;
			ln = '0;
			ld = '0;
		end else begin
			lb = cn.ax;
			ln = mul6(EDGE - cn.ax, wy_s1 - cn.ay);
			ld = EDGE - cn.ay;
		end

		// Right edge of the span.
		if (b_le) begin
			rb = (by == '0) ? EDGE : '0;
			rn = mul6(bx, wy_s1);
			rd = by;
		end else if (by == EDGE) begin
			rb = EDGE;
			rn = '0;
			rd = '0;
		end else begin
			rb = bx;
			rn = mul6(EDGE - bx, wy_s1 - by);
			rd = EDGE - by;
		end

		// Source start point walks down the left tile side, then along the bottom.
		if (a_le) begin
			sn = mul6(EDGE, wy_s1);
			sd = cn.ay;
		end else begin
			sn = mul6(EDGE, wy_s1 - cn.ay);
			sd = EDGE - cn.ay;
		end

		// Source end point walks along the top, then down the right tile side.
		if (b_le) begin
			en_num = mul6(EDGE, wy_s1);
			ed     = by;
		end else begin
			en_num = mul6(EDGE, wy_s1 - by);
			ed     = EDGE - by;
		end
	end

	side_t                 side_s2;
	logic [SPAN_NUM_W-1:0] ln_s2, rn_s2, sn_s2, en_s2;
	tcoord_t               ld_s2, rd_s2, sd_s2, ed_s2, lb_s2, rb_s2;
	logic                  sa_s2, eb_s2, ez_s2;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s2 <= side_in2;
			ln_s2   <= ln;
			rn_s2   <= rn;
			sn_s2   <= sn;
			en_s2   <= en_num;
			ld_s2   <= ld;
			rd_s2   <= rd;
			sd_s2   <= sd;
			ed_s2   <= ed;
			lb_s2   <= lb;
			rb_s2   <= rb;
			sa_s2   <= a_le;
			eb_s2   <= b_le;
			ez_s2   <= (by == '0);
		end
	end

	// ---------------------------------------------------------------- S3
	logic [SPAN_NUM_W-1:0] lq_s3, rq_s3, sq_s3, eq_s3;

	ttpm_recip_div #(.NUM_W(SPAN_NUM_W)) u_div_left (
		.clk(clk), .en(pipe_en), .num(ln_s2), .den(ld_s2), .quo(lq_s3)
	);
	ttpm_recip_div #(.NUM_W(SPAN_NUM_W)) u_div_right (
		.clk(clk), .en(pipe_en), .num(rn_s2), .den(rd_s2), .quo(rq_s3)
	);
	ttpm_recip_div #(.NUM_W(SPAN_NUM_W)) u_div_start (
		.clk(clk), .en(pipe_en), .num(sn_s2), .den(sd_s2), .quo(sq_s3)
	);
	ttpm_recip_div #(.NUM_W(SPAN_NUM_W)) u_div_end (
		.clk(clk), .en(pipe_en), .num(en_s2), .den(ed_s2), .quo(eq_s3)
	);

	side_t   side_s3;
	tcoord_t lb_s3, rb_s3;
	logic    sa_s3, eb_s3, ez_s3;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s3 <= side_s2;
			lb_s3   <= lb_s2;
			rb_s3   <= rb_s2;
			sa_s3   <= sa_s2;
			eb_s3   <= eb_s2;
			ez_s3   <= ez_s2;
		end
	end

	// ---------------------------------------------------------------- S4
	// The edge quotients never exceed the tile edge, so six bits hold them.
	tcoord_t                left, right_raw, right, sx, sy, ex, ey;
	tcoord_t                dxmag, dymag, adv, lenm1;
	logic                   dxneg, dyneg, span;

	always_comb begin
		left      = lb_s3 + lq_s3[TILE_BITS-1:0];
		right_raw = rb_s3 + rq_s3[TILE_BITS-1:0];
		right     = (left > right_raw) ? left : right_raw;

		sx = sa_s3 ? '0 : sq_s3[TILE_BITS-1:0];
		sy = sa_s3 ? sq_s3[TILE_BITS-1:0] : EDGE;
		ex = eb_s3 ? (ez_s3 ? EDGE : eq_s3[TILE_BITS-1:0]) : EDGE;
		ey = eb_s3 ? '0 : eq_s3[TILE_BITS-1:0];

		// The step is a truncating division of a signed delta: divide the
		// magnitude and put the sign back afterwards.
		dxneg = ex < sx;
		dyneg = ey < sy;
		dxmag = dxneg ? (sx - ex) : (ex - sx);
		dymag = dyneg ? (sy - ey) : (ey - sy);

		span  = (side_s3.wx >= left) && (side_s3.wx <= right);
		adv   = side_s3.wx - left;
		lenm1 = right - left;
	end

	side_t                 side_s4;
	tcoord_t               sx_s4, sy_s4, adv_s4, lenm1_s4;
	logic                  dxneg_s4, dyneg_s4, span_s4;
	logic [STEP_NUM_W-1:0] xnum_s4, ynum_s4;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s4  <= side_s3;
			sx_s4    <= sx;
			sy_s4    <= sy;
			adv_s4   <= adv;
			lenm1_s4 <= lenm1;
			dxneg_s4 <= dxneg;
			dyneg_s4 <= dyneg;
			span_s4  <= span;
			xnum_s4  <= {dxmag, {FIX_BITS{1'b0}}};
			ynum_s4  <= {dymag, {FIX_BITS{1'b0}}};
		end
	end

	// ---------------------------------------------------------------- S5
	// A one-pixel span divides by zero and gets a zero step from the divider.
	logic [STEP_NUM_W-1:0] qx_s5, qy_s5;

	ttpm_recip_div #(.NUM_W(STEP_NUM_W)) u_div_step_x (
		.clk(clk), .en(pipe_en), .num(xnum_s4), .den(lenm1_s4), .quo(qx_s5)
	);
	ttpm_recip_div #(.NUM_W(STEP_NUM_W)) u_div_step_y (
		.clk(clk), .en(pipe_en), .num(ynum_s4), .den(lenm1_s4), .quo(qy_s5)
	);

	side_t   side_s5;
	tcoord_t sx_s5, sy_s5, adv_s5;
	logic    dxneg_s5, dyneg_s5, span_s5;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s5  <= side_s4;
			sx_s5    <= sx_s4;
			sy_s5    <= sy_s4;
			adv_s5   <= adv_s4;
			dxneg_s5 <= dxneg_s4;
			dyneg_s5 <= dyneg_s4;
			span_s5  <= span_s4;
		end
	end

	// ---------------------------------------------------------------- S6
	logic signed [STEP_NUM_W:0]  stx, sty;
	logic signed [TILE_BITS:0]   adv_sgn;

	assign stx     = dxneg_s5 ? -signed'({1'b0, qx_s5}) : signed'({1'b0, qx_s5});
	assign sty     = dyneg_s5 ? -signed'({1'b0, qy_s5}) : signed'({1'b0, qy_s5});
	assign adv_sgn = signed'({1'b0, adv_s5});

	side_t                    side_s6;
	tcoord_t                  sx_s6, sy_s6;
	logic                     span_s6;
	logic signed [PROD_W-1:0] prod_x_s6, prod_y_s6;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s6   <= side_s5;
			sx_s6     <= sx_s5;
			sy_s6     <= sy_s5;
			span_s6   <= span_s5;
			prod_x_s6 <= PROD_W'(stx) * PROD_W'(adv_sgn);
			prod_y_s6 <= PROD_W'(sty) * PROD_W'(adv_sgn);
		end
	end

	// ---------------------------------------------------------------- S7
	// Floor of the 16.16 offset is an arithmetic shift; only the low coordinate
	// bits of it matter once the sum wraps to the coordinate width.
	logic [COORD_W-1:0] map_x, map_y;
	logic               blank_d, second_d;
	logic [COORD_W-1:0] src_x_d, src_y_d;
	logic [GLOSS_W-1:0] gloss_d;

	assign map_x = {side_s6.tx, {TILE_BITS{1'b0}}} + COORD_W'(sx_s6)
	             + prod_x_s6[FIX_BITS+COORD_W-1:FIX_BITS];
	assign map_y = {side_s6.ty, {TILE_BITS{1'b0}}} + COORD_W'(sy_s6)
	             + prod_y_s6[FIX_BITS+COORD_W-1:FIX_BITS];

	always_comb begin
		blank_d  = 1'b1;
		second_d = 1'b0;
		src_x_d  = '0;
		src_y_d  = '0;
		gloss_d  = '0;
		if (side_s6.neg) begin
			// Nothing to show outside the image.
		end else if (side_s6.pass) begin
			blank_d  = 1'b0;
			second_d = side_s6.second;
			src_x_d  = {side_s6.tx, side_s6.wx};
			src_y_d  = {side_s6.ty, side_s6.wy};
		end else begin
			second_d = side_s6.second;
			gloss_d  = side_s6.gloss;
			if (span_s6) begin
				blank_d = 1'b0;
				src_x_d = map_x;
				src_y_d = map_y;
			end
		end
	end

	logic               blank_s7, second_s7;
	logic [COORD_W-1:0] src_x_s7, src_y_s7;
	logic [GLOSS_W-1:0] gloss_s7;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			blank_s7  <= blank_d;
			second_s7 <= second_d;
			src_x_s7  <= src_x_d;
			src_y_s7  <= src_y_d;
			gloss_s7  <= gloss_d;
		end
	end

	assign out_valid    = v_s7;
	assign blank        = blank_s7;
	assign second_image = second_s7;
	assign source_x     = src_x_s7;
	assign source_y     = src_y_s7;
	assign gloss_level  = gloss_s7;

	// ---------------------------------------------------------------- checks
	// A blank pixel never carries a sample position.
	a_blank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && blank |-> source_x == '0 && source_y == '0)
		else $error("blank result carries a source position");

	// Gloss only lights tiles early in the turn, which still show the first image.
	a_gloss_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gloss_level != '0 |-> !second_image)
		else $error("gloss on a second-image result");

	// A waiting result freezes every stage of the pipeline.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			out_valid && $stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6}))
		else $error("pipeline moved under a stalled result");

	// A pixel in a one-pixel span sits exactly at the span start.
	a_span_step: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && span_s4 && lenm1_s4 == '0 |-> adv_s4 == '0)
		else $error("advance beyond a one-pixel span");

endmodule
